[design/cbs_pkg.sv]
// Shared constants, types and helpers for the cubic B-spline point and tangent evaluator.
// Used by cbs_div, cbs_blend and cubic_bspline_point_tangent_eval; depends on nothing.
`timescale 1ns / 1ps
package cbs_pkg;

  localparam int POINT_SLOTS = 64;
  localparam int KNOT_SLOTS  = 128;
  localparam int PIDX_W      = $clog2(POINT_SLOTS);
  localparam int KIDX_W      = $clog2(KNOT_SLOTS);
  localparam int KNOT_TAPS   = 6;
  localparam int PT_TAPS     = 4;
  localparam int DIV_STEPS   = 32;
  localparam int DIV_LAT     = DIV_STEPS + 2;
  localparam int BLEND_LAT   = DIV_LAT + 2;

  localparam logic [31:0] ONE_Q16 = 32'h0001_0000;
  localparam logic [31:0] S32_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] S32_MIN = 32'h8000_0000;
  localparam logic [63:0] S63_MAX = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] S63_MIN = 64'h8000_0000_0000_0001;

  typedef logic [KIDX_W-1:0] kidx_t;
  typedef logic [PIDX_W-1:0] pidx_t;

  typedef enum logic [1:0] {
    OP_LOAD_KNOT  = 2'd0,
    OP_LOAD_POINT = 2'd1,
    OP_EVAL       = 2'd2
  } op_t;

  typedef enum logic [1:0] {
    ST_OK       = 2'd0,
    ST_BAD_SPAN = 2'd1,
    ST_ZERO_DEN = 2'd2,
    ST_BAD_SLOT = 2'd3
  } status_t;

  typedef struct packed {
    logic    valid;
    logic    is_eval;
    logic    rat;
    status_t status;
  } head_t;

  // Multipliers and denominators travel with each transaction through the triangle.
  typedef struct packed {
    head_t            h;
    logic [5:0][32:0] m;
    logic [5:0][32:0] d;
  } side_t;

  typedef struct packed {
    head_t            h;
    logic [2:0][31:0] p33;
    logic [2:0][31:0] tg;
    logic [31:0]      w33;
    logic [31:0]      w32;
  } tail_t;

  function automatic logic [31:0] sat32_48(input logic [47:0] v);
    if (v[47:31] == {17{v[47]}}) begin
      return v[31:0];
    end
    return v[47] ? S32_MIN : S32_MAX;
  endfunction

endpackage

[design/cubic_bspline_point_tangent_eval.sv]
// Top level of the cubic B-spline / NURBS point and tangent evaluator (Q16.16).
// Depends on cbs_pkg, cbs_blend and cbs_div.
//
//  channel   handshake            payload
//  input     in_valid / in_ready  op, slot, knot_value, coord_x/y/z, weight, span, param
//  result    out_valid/out_ready  status, point_x/y/z/w, tangent_x/y/z/w
//  config    cfg_valid/cfg_ready  cfg_data (rational mode)
//
// One transaction is taken every cycle while the result channel is not stalled. Each
// result passes through the three chained triangle levels and the final division, each
// built from dividers that develop one quotient bit per stage.
// Reset is synchronous and clears the valid bits and the mode, but not the output data.
// A stalled result holds the whole pipeline in place, so nothing is lost or repeated.
`timescale 1ns / 1ps
module cubic_bspline_point_tangent_eval (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         op,
  input  logic [6:0]         slot,
  input  logic signed [31:0] knot_value,
  input  logic signed [31:0] coord_x,
  input  logic signed [31:0] coord_y,
  input  logic signed [31:0] coord_z,
  input  logic [30:0]        weight,
  input  logic [6:0]         span,
  input  logic signed [31:0] param,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         status,
  output logic signed [31:0] point_x,
  output logic signed [31:0] point_y,
  output logic signed [31:0] point_z,
  output logic signed [31:0] point_w,
  output logic signed [31:0] tangent_x,
  output logic signed [31:0] tangent_y,
  output logic signed [31:0] tangent_z,
  output logic signed [31:0] tangent_w,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic               cfg_data
);

  localparam int BL = cbs_pkg::BLEND_LAT;

  logic en;
  logic accept;
  logic rational_mode;

  assign en        = !out_valid || out_ready;
  assign in_ready  = en;
  assign cfg_ready = 1'b1;
  assign accept    = in_valid && in_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      rational_mode <= 1'b0;
    end else if (cfg_valid) begin
      rational_mode <= cfg_data;
    end
  end

  // ---------------- entry decode and table access ----------------
  cbs_pkg::status_t st0;
  logic             ev0;
  logic             wr_knot;
  logic             wr_pt;

  always_comb begin
    st0     = cbs_pkg::ST_OK;
    ev0     = 1'b0;
    wr_knot = 1'b0;
    wr_pt   = 1'b0;
    case (cbs_pkg::op_t'(op))
      cbs_pkg::OP_LOAD_KNOT: begin
        if (int'(slot) < cbs_pkg::KNOT_SLOTS) wr_knot = accept;
        else st0 = cbs_pkg::ST_BAD_SLOT;
      end
      cbs_pkg::OP_LOAD_POINT: begin
        if (int'(slot) < cbs_pkg::POINT_SLOTS) wr_pt = accept;
        else st0 = cbs_pkg::ST_BAD_SLOT;
      end
      cbs_pkg::OP_EVAL: begin
        ev0 = 1'b1;
        if (int'(span) < 3 || int'(span) > cbs_pkg::POINT_SLOTS - 1 ||
            int'(span) + 3 > cbs_pkg::KNOT_SLOTS - 1) begin
          st0 = cbs_pkg::ST_BAD_SPAN;
        end
      end
      default: st0 = cbs_pkg::ST_BAD_SLOT;
    endcase
  end

  // Each knot tap and each point tap has its own copy of the table, so every copy is
  // written at one address and read at one address per cycle.
  logic [31:0]      knot_mem [cbs_pkg::KNOT_TAPS][cbs_pkg::KNOT_SLOTS];
  logic [3:0][31:0] pt_mem   [cbs_pkg::PT_TAPS][cbs_pkg::POINT_SLOTS];
  logic [5:0][31:0]       kn1;
  logic [3:0][3:0][31:0]  pt1;
  cbs_pkg::head_t         h1;
  logic [31:0]            t1;

  always_ff @(posedge clk) begin
    for (int k = 0; k < cbs_pkg::KNOT_TAPS; k++) begin
      if (wr_knot) knot_mem[k][cbs_pkg::kidx_t'(slot)] <= knot_value;
      if (en) kn1[k] <= knot_mem[k][cbs_pkg::kidx_t'(int'(span) + k - 2)];
    end
    for (int k = 0; k < cbs_pkg::PT_TAPS; k++) begin
      if (wr_pt) begin
        pt_mem[k][cbs_pkg::pidx_t'(slot)] <= {{1'b0, weight}, coord_z, coord_y, coord_x};
      end
      if (en) pt1[k] <= pt_mem[k][cbs_pkg::pidx_t'(int'(span) + k - 3)];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      h1.valid <= 1'b0;
    end else if (en) begin
      h1 <= '{valid: accept, is_eval: ev0, rat: rational_mode, status: st0};
    end
    if (en) t1 <= param;
  end

  // ---------------- knot differences and weighting products ----------------
  logic [5:0][32:0]      m1;
  logic [5:0][32:0]      d1;
  logic                  zero1;
  logic [3:0][2:0][63:0] wprod1;
  cbs_pkg::head_t        h1_chk;
  cbs_pkg::side_t        s2;
  logic [3:0][2:0][63:0] wp2;
  logic [3:0][3:0][31:0] raw2;

  always_comb begin
    m1[0] = {t1[31], t1} - {kn1[0][31], kn1[0]};
    m1[1] = {t1[31], t1} - {kn1[1][31], kn1[1]};
    m1[2] = {t1[31], t1} - {kn1[2][31], kn1[2]};
    m1[3] = {kn1[3][31], kn1[3]} - {t1[31], t1};
    m1[4] = {kn1[4][31], kn1[4]} - {t1[31], t1};
    m1[5] = {kn1[5][31], kn1[5]} - {t1[31], t1};
    d1[0] = {kn1[3][31], kn1[3]} - {kn1[2][31], kn1[2]};
    d1[1] = {kn1[3][31], kn1[3]} - {kn1[1][31], kn1[1]};
    d1[2] = {kn1[4][31], kn1[4]} - {kn1[2][31], kn1[2]};
    d1[3] = {kn1[3][31], kn1[3]} - {kn1[0][31], kn1[0]};
    d1[4] = {kn1[4][31], kn1[4]} - {kn1[1][31], kn1[1]};
    d1[5] = {kn1[5][31], kn1[5]} - {kn1[2][31], kn1[2]};
    zero1 = 1'b0;
    for (int k = 0; k < 6; k++) begin
      if (d1[k] == 33'd0) zero1 = 1'b1;
    end
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        wprod1[k][c] = $signed(pt1[k][c]) * $signed(pt1[k][3]);
      end
    end
    h1_chk = h1;
    if (h1.is_eval && h1.status == cbs_pkg::ST_OK && zero1) begin
      h1_chk.status = cbs_pkg::ST_ZERO_DEN;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s2.h.valid <= 1'b0;
    end else if (en) begin
      s2.h <= h1_chk;
    end
    if (en) begin
      s2.m <= m1;
      s2.d <= d1;
      wp2  <= wprod1;
      raw2 <= pt1;
    end
  end

  // ---------------- homogeneous control points ----------------
  logic [3:0][3:0][31:0] pnext;
  logic [47:0]           wq;
  cbs_pkg::side_t        s3;
  logic [3:0][3:0][31:0] p3;

  always_comb begin
    wq = '0;
    for (int k = 0; k < 4; k++) begin
      for (int c = 0; c < 3; c++) begin
        // Arithmetic shift floors, so a negative product with a remainder moves up by one.
        wq = wp2[k][c][63:16] + {47'd0, (wp2[k][c][63] && wp2[k][c][15:0] != 16'd0)};
        pnext[k][c] = s2.h.rat ? cbs_pkg::sat32_48(wq) : raw2[k][c];
      end
      pnext[k][3] = s2.h.rat ? raw2[k][3] : cbs_pkg::ONE_Q16;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s3.h.valid <= 1'b0;
    end else if (en) begin
      s3 <= s2;
    end
    if (en) p3 <= pnext;
  end

  // ---------------- de Boor triangle ----------------
  cbs_pkg::side_t   side_sh [3*BL];
  logic [1:0][3:0][31:0] pp_sh [BL];
  cbs_pkg::side_t   tap1;
  cbs_pkg::side_t   tap2;
  cbs_pkg::side_t   tap3;
  logic [3:0][31:0] p11;
  logic [3:0][31:0] p12;
  logic [3:0][31:0] p13;
  logic [3:0][31:0] p22;
  logic [3:0][31:0] p32;
  logic [3:0][31:0] p33;

  assign tap1 = side_sh[BL-1];
  assign tap2 = side_sh[2*BL-1];
  assign tap3 = side_sh[3*BL-1];

  for (genvar c = 0; c < 4; c++) begin : g_comp
    cbs_blend u_p11 (.clk(clk), .en(en), .pa(p3[0][c]), .ma(s3.m[3]), .pb(p3[1][c]),
                     .mb(s3.m[0]), .den(s3.d[3]), .q(p11[c]));
    cbs_blend u_p12 (.clk(clk), .en(en), .pa(p3[1][c]), .ma(s3.m[4]), .pb(p3[2][c]),
                     .mb(s3.m[1]), .den(s3.d[4]), .q(p12[c]));
    cbs_blend u_p13 (.clk(clk), .en(en), .pa(p3[2][c]), .ma(s3.m[5]), .pb(p3[3][c]),
                     .mb(s3.m[2]), .den(s3.d[5]), .q(p13[c]));
    cbs_blend u_p22 (.clk(clk), .en(en), .pa(p11[c]), .ma(tap1.m[3]), .pb(p12[c]),
                     .mb(tap1.m[1]), .den(tap1.d[1]), .q(p22[c]));
    cbs_blend u_p32 (.clk(clk), .en(en), .pa(p12[c]), .ma(tap1.m[4]), .pb(p13[c]),
                     .mb(tap1.m[2]), .den(tap1.d[2]), .q(p32[c]));
    cbs_blend u_p33 (.clk(clk), .en(en), .pa(p22[c]), .ma(tap2.m[3]), .pb(p32[c]),
                     .mb(tap2.m[2]), .den(tap2.d[0]), .q(p33[c]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < 3*BL; j++) side_sh[j].h.valid <= 1'b0;
    end else if (en) begin
      side_sh[0] <= s3;
      for (int j = 1; j < 3*BL; j++) side_sh[j] <= side_sh[j-1];
    end
    if (en) begin
      pp_sh[0] <= {p32, p22};
      for (int j = 1; j < BL; j++) pp_sh[j] <= pp_sh[j-1];
    end
  end

  // ---------------- tangent difference and weight check ----------------
  logic [3:0][31:0] p22d;
  logic [3:0][31:0] p32d;
  logic [32:0]      tdiff [3];
  cbs_pkg::tail_t   tail_next;
  cbs_pkg::tail_t   tl;

  assign p22d = pp_sh[BL-1][0];
  assign p32d = pp_sh[BL-1][1];

  always_comb begin
    tail_next.h = tap3.h;
    if (tap3.h.is_eval && tap3.h.status == cbs_pkg::ST_OK && tap3.h.rat &&
        (p33[3] == 32'd0 || p32d[3] == 32'd0)) begin
      tail_next.h.status = cbs_pkg::ST_ZERO_DEN;
    end
    for (int c = 0; c < 3; c++) begin
      tdiff[c]          = {p32d[c][31], p32d[c]} - {p22d[c][31], p22d[c]};
      tail_next.tg[c]   = cbs_pkg::sat32_48({{15{tdiff[c][32]}}, tdiff[c]});
      tail_next.p33[c]  = p33[c];
    end
    tail_next.w33 = p33[3];
    tail_next.w32 = p32d[3];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      tl.h.valid <= 1'b0;
    end else if (en) begin
      tl.h <= tail_next.h;
    end
    if (en) begin
      tl.p33 <= tail_next.p33;
      tl.tg  <= tail_next.tg;
      tl.w33 <= tail_next.w33;
      tl.w32 <= tail_next.w32;
    end
  end

  // ---------------- rational division ----------------
  cbs_pkg::tail_t   fin_sh [cbs_pkg::DIV_LAT];
  cbs_pkg::tail_t   fin;
  logic [2:0][31:0] pdiv;
  logic [2:0][31:0] tdiv;

  assign fin = fin_sh[cbs_pkg::DIV_LAT-1];

  for (genvar c = 0; c < 3; c++) begin : g_rdiv
    cbs_div u_pdiv (.clk(clk), .en(en),
                    .num({{16{tl.p33[c][31]}}, tl.p33[c], 16'h0000}),
                    .den({tl.w33[31], tl.w33}), .q(pdiv[c]));
    cbs_div u_tdiv (.clk(clk), .en(en),
                    .num({{16{tl.tg[c][31]}}, tl.tg[c], 16'h0000}),
                    .den({tl.w32[31], tl.w32}), .q(tdiv[c]));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int j = 0; j < cbs_pkg::DIV_LAT; j++) fin_sh[j].h.valid <= 1'b0;
    end else if (en) begin
      fin_sh[0] <= tl;
      for (int j = 1; j < cbs_pkg::DIV_LAT; j++) fin_sh[j] <= fin_sh[j-1];
    end
  end

  // ---------------- output register ----------------
  logic out_eval;
  logic out_rat;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= fin.h.valid;
    end
    if (en) begin
      status   <= fin.h.status;
      out_eval <= fin.h.is_eval;
      out_rat  <= fin.h.rat;
      if (!fin.h.is_eval || fin.h.status != cbs_pkg::ST_OK) begin
        point_x   <= '0;
        point_y   <= '0;
        point_z   <= '0;
        point_w   <= '0;
        tangent_x <= '0;
        tangent_y <= '0;
        tangent_z <= '0;
        tangent_w <= '0;
      end else if (fin.h.rat) begin
        point_x   <= pdiv[0];
        point_y   <= pdiv[1];
        point_z   <= pdiv[2];
        point_w   <= fin.w33;
        tangent_x <= tdiv[0];
        tangent_y <= tdiv[1];
        tangent_z <= tdiv[2];
        tangent_w <= fin.w32;
      end else begin
        point_x   <= fin.p33[0];
        point_y   <= fin.p33[1];
        point_z   <= fin.p33[2];
        point_w   <= cbs_pkg::ONE_Q16;
        tangent_x <= fin.tg[0];
        tangent_y <= fin.tg[1];
        tangent_z <= fin.tg[2];
        tangent_w <= cbs_pkg::ONE_Q16;
      end
    end
  end

  // ---------------- assertions ----------------
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != cbs_pkg::ST_OK |->
      point_x == 0 && point_w == 0 && tangent_x == 0 && tangent_w == 0)
    else $error("flagged result carries non-zero fields");

  a_plain_weight: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_eval && !out_rat && status == cbs_pkg::ST_OK |->
      point_w == cbs_pkg::ONE_Q16 && tangent_w == cbs_pkg::ONE_Q16)
    else $error("non-rational result with weight other than one");

  a_load_status: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_eval |->
      status == cbs_pkg::ST_OK || status == cbs_pkg::ST_BAD_SLOT)
    else $error("load transaction reported a span or denominator fault");

  a_reset_clear: assert property (@(posedge clk)
    $past(rst) |-> !out_valid && !side_sh[0].h.valid && !tl.h.valid)
    else $error("valid bit survived reset");

endmodule

[design/cbs_div.sv]
// Pipelined signed divider, one quotient bit per stage, quotient saturated to 32 bits.
// Truncates toward zero. Depends on cbs_pkg.
`timescale 1ns / 1ps
module cbs_div (
  input  logic               clk,
  input  logic               en,
  input  logic signed [63:0] num,
  input  logic signed [32:0] den,
  output logic signed [31:0] q
);

  logic [32:0] rem [cbs_pkg::DIV_STEPS+1];
  logic [31:0] low [cbs_pkg::DIV_STEPS+1];
  logic [31:0] quo [cbs_pkg::DIV_STEPS+1];
  logic [32:0] dab [cbs_pkg::DIV_STEPS+1];
  logic        neg [cbs_pkg::DIV_STEPS+1];
  logic        ovf [cbs_pkg::DIV_STEPS+1];

  logic [33:0] trial    [cbs_pkg::DIV_STEPS];
  logic [33:0] diff     [cbs_pkg::DIV_STEPS];
  logic [32:0] rem_next [cbs_pkg::DIV_STEPS];
  logic [31:0] quo_next [cbs_pkg::DIV_STEPS];

  logic [63:0] nneg;
  logic [62:0] nabs;
  logic [32:0] dabs_in;
  logic [31:0] q_next;

  always_comb begin
    nneg    = 64'd0 - num;
    nabs    = num[63] ? nneg[62:0] : num[62:0];
    dabs_in = den[32] ? (33'd0 - den) : den;
    for (int i = 0; i < cbs_pkg::DIV_STEPS; i++) begin
      trial[i] = {rem[i], low[i][31]};
      diff[i]  = trial[i] - {1'b0, dab[i]};
      if (trial[i] >= {1'b0, dab[i]}) begin
        rem_next[i] = diff[i][32:0];
        quo_next[i] = {quo[i][30:0], 1'b1};
      end else begin
        rem_next[i] = trial[i][32:0];
        quo_next[i] = {quo[i][30:0], 1'b0};
      end
    end
  end

  // The overflow flag stands for a magnitude of 2^32 or more, so only 32 bits are developed.
  always_comb begin
    if (neg[cbs_pkg::DIV_STEPS]) begin
      if (ovf[cbs_pkg::DIV_STEPS] || quo[cbs_pkg::DIV_STEPS] > cbs_pkg::S32_MIN) begin
        q_next = cbs_pkg::S32_MIN;
      end else begin
        q_next = 32'd0 - quo[cbs_pkg::DIV_STEPS];
      end
    end else if (ovf[cbs_pkg::DIV_STEPS] || quo[cbs_pkg::DIV_STEPS][31]) begin
      q_next = cbs_pkg::S32_MAX;
    end else begin
      q_next = quo[cbs_pkg::DIV_STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rem[0] <= {2'b00, nabs[62:32]};
      low[0] <= nabs[31:0];
      quo[0] <= '0;
      dab[0] <= dabs_in;
      neg[0] <= num[63] ^ den[32];
      ovf[0] <= ({2'b00, nabs[62:32]} >= dabs_in);
      for (int i = 0; i < cbs_pkg::DIV_STEPS; i++) begin
        rem[i+1] <= rem_next[i];
        low[i+1] <= {low[i][30:0], 1'b0};
        quo[i+1] <= quo_next[i];
        dab[i+1] <= dab[i];
        neg[i+1] <= neg[i];
        ovf[i+1] <= ovf[i];
      end
      q <= q_next;
    end
  end

endmodule

[design/cbs_blend.sv]
// One de Boor triangle node: sat32(sat64(pa*ma + pb*mb) / den), fully pipelined.
// Depends on cbs_pkg and cbs_div.
`timescale 1ns / 1ps
module cbs_blend (
  input  logic               clk,
  input  logic               en,
  input  logic signed [31:0] pa,
  input  logic signed [32:0] ma,
  input  logic signed [31:0] pb,
  input  logic signed [32:0] mb,
  input  logic signed [32:0] den,
  output logic signed [31:0] q
);

  logic signed [64:0] prod_a;
  logic signed [64:0] prod_b;
  logic signed [32:0] den1;
  logic signed [32:0] den2;
  logic signed [65:0] sum;
  logic        [63:0] sum_sat;
  logic signed [63:0] sum_r;

  always_comb begin
    sum = {prod_a[64], prod_a} + {prod_b[64], prod_b};
    if (sum[65:63] != 3'b000 && sum[65:63] != 3'b111) begin
      sum_sat = sum[65] ? cbs_pkg::S63_MIN : cbs_pkg::S63_MAX;
    end else if (sum[63:0] == 64'h8000_0000_0000_0000) begin
      // The sum saturates symmetrically, so the most negative code is pulled in by one.
      sum_sat = cbs_pkg::S63_MIN;
    end else begin
      sum_sat = sum[63:0];
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      prod_a <= pa * ma;
      prod_b <= pb * mb;
      den1   <= den;
      sum_r  <= sum_sat;
      den2   <= den1;
    end
  end

  cbs_div u_div (
    .clk (clk),
    .en  (en),
    .num (sum_r),
    .den (den2),
    .q   (q)
  );

endmodule

[verif/testbench.sv]
// Self-checking testbench for cubic_bspline_point_tangent_eval (de Boor evaluator, Q16.16).
// Depends on cbs_pkg and the block under test; drives random idling and stalls on both channels.
`timescale 1ns / 1ps
module testbench;

  localparam logic [1:0] OP_UNDEF = 2'd3;
  localparam int LATENCY = 146;

  typedef struct {
    logic [1:0]  op;
    logic [6:0]  slot;
    logic [31:0] knot;
    logic [31:0] cx;
    logic [31:0] cy;
    logic [31:0] cz;
    logic [30:0] w;
    logic [6:0]  span;
    logic [31:0] t;
  } item_t;

  typedef struct {
    logic [1:0]  status;
    logic [31:0] f [8];
  } curve_res_t;

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0, in_ready, out_valid, out_ready = 0;
  logic cfg_valid = 0, cfg_ready, cfg_data = 0;
  logic [1:0] op = 0;
  logic [6:0] slot = 0, span = 0;
  logic signed [31:0] knot_value = 0, coord_x = 0, coord_y = 0, coord_z = 0, param = 0;
  logic [30:0] weight = 0;
  logic [1:0] status;
  logic signed [31:0] point_x, point_y, point_z, point_w;
  logic signed [31:0] tangent_x, tangent_y, tangent_z, tangent_w;

  // Predictor state.
  logic [31:0] knot_mem [cbs_pkg::KNOT_SLOTS];
  logic [31:0] px_mem [cbs_pkg::POINT_SLOTS];
  logic [31:0] py_mem [cbs_pkg::POINT_SLOTS];
  logic [31:0] pz_mem [cbs_pkg::POINT_SLOTS];
  logic [31:0] pw_mem [cbs_pkg::POINT_SLOTS];
  logic        rational = 0;

  curve_res_t pending_results [$];
  int   error_count = 0;
  logic quiet = 0;

  always #5 clk = ~clk;

  cubic_bspline_point_tangent_eval u_top (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready),
    .op(op), .slot(slot), .knot_value(knot_value),
    .coord_x(coord_x), .coord_y(coord_y), .coord_z(coord_z), .weight(weight),
    .span(span), .param(param),
    .out_valid(out_valid), .out_ready(out_ready),
    .status(status),
    .point_x(point_x), .point_y(point_y), .point_z(point_z), .point_w(point_w),
    .tangent_x(tangent_x), .tangent_y(tangent_y), .tangent_z(tangent_z),
    .tangent_w(tangent_w),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_data(cfg_data)
  );

  function automatic longint clamp32(input logic signed [127:0] v);
    if (v > 128'sh7FFF_FFFF) return 64'sh7FFF_FFFF;
    if (v < -128'sh8000_0000) return -64'sh8000_0000;
    return longint'(v);
  endfunction

  // One node of the triangle: (pa*ma + pb*mb) / d with the sum clamped to 64 bits.
  function automatic longint tri_node(input longint pa, ma, pb, mb, d);
    logic signed [127:0] a, b, c, e, s, dd, lim;
    a = pa; b = ma; c = pb; e = mb; dd = d;
    lim = 128'sh7FFF_FFFF_FFFF_FFFF;
    s = a * b + c * e;
    if (s > lim) s = lim;
    if (s < -lim) s = -lim;
    return clamp32(s / dd);
  endfunction

  function automatic longint sx(input logic [31:0] v);
    return longint'($signed(v));
  endfunction

  function automatic curve_res_t evaluate_curve(input item_t it);
    curve_res_t r;
    longint tt, w;
    longint kn [6];
    longint m [6];
    longint d [6];
    longint pt [4][4];
    longint p11, p12, p13, p22, p32, p33, tg;
    longint n22 [4];
    longint n32 [4];
    longint n33 [4];
    r.status = cbs_pkg::ST_OK;
    for (int i = 0; i < 8; i++) r.f[i] = '0;
    case (it.op)
      cbs_pkg::OP_LOAD_KNOT: knot_mem[it.slot] = it.knot;
      cbs_pkg::OP_LOAD_POINT: begin
        if (it.slot < cbs_pkg::POINT_SLOTS) begin
          px_mem[it.slot] = it.cx;
          py_mem[it.slot] = it.cy;
          pz_mem[it.slot] = it.cz;
          pw_mem[it.slot] = {1'b0, it.w};
        end else begin
          r.status = cbs_pkg::ST_BAD_SLOT;
        end
      end
      OP_UNDEF: r.status = cbs_pkg::ST_BAD_SLOT;
      default: begin
        if (it.span < 3 || it.span > cbs_pkg::POINT_SLOTS - 1 ||
            it.span + 3 > cbs_pkg::KNOT_SLOTS - 1) begin
          r.status = cbs_pkg::ST_BAD_SPAN;
          return r;
        end
        tt = sx(it.t);
        for (int k = 0; k < 6; k++) kn[k] = sx(knot_mem[it.span - 2 + k]);
        m[0] = tt - kn[0]; m[1] = tt - kn[1]; m[2] = tt - kn[2];
        m[3] = kn[3] - tt; m[4] = kn[4] - tt; m[5] = kn[5] - tt;
        d[0] = kn[3] - kn[2]; d[1] = kn[3] - kn[1]; d[2] = kn[4] - kn[2];
        d[3] = kn[3] - kn[0]; d[4] = kn[4] - kn[1]; d[5] = kn[5] - kn[2];
        for (int k = 0; k < 6; k++) if (d[k] == 0) r.status = cbs_pkg::ST_ZERO_DEN;
        if (r.status != cbs_pkg::ST_OK) return r;
        for (int k = 0; k < 4; k++) begin
          w = sx(pw_mem[it.span - 3 + k]);
          pt[k][0] = sx(px_mem[it.span - 3 + k]);
          pt[k][1] = sx(py_mem[it.span - 3 + k]);
          pt[k][2] = sx(pz_mem[it.span - 3 + k]);
          pt[k][3] = 65536;
          if (rational) begin
            for (int c = 0; c < 3; c++) pt[k][c] = clamp32((pt[k][c] * w) / 65536);
            pt[k][3] = w;
          end
        end
        for (int c = 0; c < 4; c++) begin
          p11 = tri_node(pt[0][c], m[3], pt[1][c], m[0], d[3]);
          p12 = tri_node(pt[1][c], m[4], pt[2][c], m[1], d[4]);
          p13 = tri_node(pt[2][c], m[5], pt[3][c], m[2], d[5]);
          p22 = tri_node(p11, m[3], p12, m[1], d[1]);
          p32 = tri_node(p12, m[4], p13, m[2], d[2]);
          p33 = tri_node(p22, m[3], p32, m[2], d[0]);
          n22[c] = p22; n32[c] = p32; n33[c] = p33;
        end
        if (rational && (n33[3] == 0 || n32[3] == 0)) begin
          r.status = cbs_pkg::ST_ZERO_DEN;
          return r;
        end
        for (int c = 0; c < 3; c++) begin
          tg = clamp32(n32[c] - n22[c]);
          if (rational) begin
            r.f[c]     = 32'(clamp32((n33[c] * 65536) / n33[3]));
            r.f[4 + c] = 32'(clamp32((tg * 65536) / n32[3]));
          end else begin
            r.f[c]     = 32'(n33[c]);
            r.f[4 + c] = 32'(tg);
          end
        end
        r.f[3] = rational ? 32'(n33[3]) : cbs_pkg::ONE_Q16;
        r.f[7] = rational ? 32'(n32[3]) : cbs_pkg::ONE_Q16;
      end
    endcase
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got, want);
    $display("mismatch at %0t: %s got %h expected %h", $realtime, what, got, want);
    error_count++;
  endtask

  // Result checker: every transaction on the result channel against the oldest prediction.
  always @(posedge clk) begin
    curve_res_t e;
    logic [31:0] got [8];
    string names [8];
    if (!rst && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", {30'd0, status}, 32'd0);
      end else begin
        e = pending_results.pop_front();
        got = '{point_x, point_y, point_z, point_w, tangent_x, tangent_y, tangent_z, tangent_w};
        names = '{"point_x", "point_y", "point_z", "point_w",
                  "tangent_x", "tangent_y", "tangent_z", "tangent_w"};
        if (status !== e.status) report_mismatch("status", {30'd0, status}, {30'd0, e.status});
        for (int i = 0; i < 8; i++) begin
          if (got[i] !== e.f[i]) report_mismatch(names[i], got[i], e.f[i]);
        end
      end
    end
  end

  // Receiver stalls in bursts.
  initial begin
    @(negedge rst);
    forever begin
      if (!quiet && $urandom_range(0, 3) == 0) begin
        out_ready = 0;
        repeat ($urandom_range(1, 7)) @(negedge clk);
      end else begin
        out_ready = 1;
        repeat ($urandom_range(1, 10)) @(negedge clk);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after acceptance with valid held high.
  task automatic send_item(input item_t it);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      in_valid = 0;
      repeat ($urandom_range(1, 7)) @(negedge clk);
    end
    op = it.op; slot = it.slot; knot_value = it.knot;
    coord_x = it.cx; coord_y = it.cy; coord_z = it.cz; weight = it.w;
    span = it.span; param = it.t;
    in_valid = 1;
    do @(posedge clk); while (!in_ready);
    pending_results.insert(pending_results.size(), evaluate_curve(it));
    @(negedge clk);
  endtask

  task automatic write_mode(input logic v);
    in_valid = 0;
    wait (pending_results.size() == 0);
    @(negedge clk);
    cfg_valid = 1;
    cfg_data = v;
    do @(posedge clk); while (!cfg_ready);
    rational = v;
    @(negedge clk);
    cfg_valid = 0;
  endtask

  function automatic item_t blank_item(input logic [1:0] o);
    item_t it;
    it = '{op: o, slot: 0, knot: 0, cx: 0, cy: 0, cz: 0, w: 0, span: 0, t: 0};
    return it;
  endfunction

  function automatic logic [31:0] small_coord();
    return 32'($signed($urandom_range(0, 32'h0020_0000)) - 32'sh0010_0000);
  endfunction

  function automatic item_t knot_item(input int k, input logic [31:0] v);
    item_t it;
    it = blank_item(cbs_pkg::OP_LOAD_KNOT);
    it.slot = 7'(k);
    it.knot = v;
    return it;
  endfunction

  function automatic item_t point_item(input int k, input logic [31:0] x, y, z,
                                       input logic [30:0] w);
    item_t it;
    it = blank_item(cbs_pkg::OP_LOAD_POINT);
    it.slot = 7'(k);
    it.cx = x; it.cy = y; it.cz = z; it.w = w;
    return it;
  endfunction

  function automatic item_t eval_item(input int sp, input logic [31:0] t);
    item_t it;
    it = blank_item(cbs_pkg::OP_EVAL);
    it.span = 7'(sp);
    it.t = t;
    return it;
  endfunction

  // Evaluation inside the span, with an occasional parameter far outside it.
  function automatic item_t random_eval();
    int sp;
    sp = $urandom_range(3, 63);
    if ($urandom_range(0, 9) == 0) return eval_item(sp, $urandom);
    return eval_item(sp, knot_mem[sp] + $urandom_range(0, 32'h0001_0000));
  endfunction

  // Every table entry is written here, so no evaluation ever reads an unwritten one.
  task automatic test_table_fill();
    for (int k = 0; k < cbs_pkg::KNOT_SLOTS; k++)
      send_item(knot_item(k, 32'(k * 65536 + $urandom_range(0, 255))));
    for (int k = 0; k < cbs_pkg::POINT_SLOTS; k++)
      send_item(point_item(k, small_coord(), small_coord(), small_coord(),
                           31'($urandom_range(16384, 262144))));
  endtask

  task automatic test_directed();
    send_item(eval_item(3, 32'h0003_8000));
    send_item(eval_item(63, 32'h003F_4000));
    send_item(eval_item(2, 32'h0002_0000));
    send_item(eval_item(64, 32'h0040_0000));
    send_item(eval_item(127, 32'h0040_0000));
    send_item(eval_item(0, 32'h0));
    send_item(blank_item(OP_UNDEF));
    send_item(point_item(64, 1, 2, 3, 4));
    send_item(point_item(127, 1, 2, 3, 4));
    send_item(knot_item(0, cbs_pkg::S32_MIN));
    send_item(knot_item(127, cbs_pkg::S32_MAX));
    // Full-scale coordinates and weights are loaded at points 10 and 11 to stress saturation.
    send_item(point_item(10, cbs_pkg::S32_MAX, cbs_pkg::S32_MIN, cbs_pkg::S32_MAX,
                         31'h7FFF_FFFF));
    send_item(point_item(11, cbs_pkg::S32_MIN, cbs_pkg::S32_MAX, cbs_pkg::S32_MIN, 31'd1));
    send_item(eval_item(12, 32'h8000_0000));
    send_item(eval_item(12, 32'h7FFF_FFFF));
    send_item(eval_item(12, knot_mem[12]));
    // A repeated knot makes a denominator vanish.
    send_item(knot_item(41, knot_mem[40]));
    send_item(eval_item(40, knot_mem[40]));
    send_item(knot_item(41, 32'(41 * 65536)));
  endtask

  task automatic test_rational();
    write_mode(1);
    send_item(eval_item(5, knot_mem[5] + 32'h8000));
    send_item(eval_item(12, knot_mem[12] + 32'h4000));
    // All weights of one span at zero leave the homogeneous point with no weight.
    for (int k = 20; k < 24; k++) send_item(point_item(k, small_coord(), 5, 6, 31'd0));
    send_item(eval_item(23, knot_mem[23] + 32'h2000));
    for (int k = 20; k < 24; k++)
      send_item(point_item(k, small_coord(), small_coord(), small_coord(), 31'd65536));
    send_item(eval_item(23, knot_mem[23] + 32'h2000));
  endtask

  task automatic test_random_mix(input int count);
    item_t it;
    int sel;
    for (int n = 0; n < count; n++) begin
      sel = $urandom_range(0, 99);
      if (sel < 60) begin
        it = random_eval();
      end else if (sel < 88) begin
        it = point_item($urandom_range(0, 63), small_coord(), small_coord(), small_coord(),
                        31'($urandom_range(16384, 262144)));
        if ($urandom_range(0, 7) == 0) begin
          it.cx = $urandom; it.cy = $urandom; it.cz = $urandom; it.w = 31'($urandom);
        end
        if ($urandom_range(0, 15) == 0) it.w = 0;
        if ($urandom_range(0, 9) == 0) it.slot = 7'($urandom);
      end else if (sel < 96) begin
        it = knot_item($urandom_range(0, 127), 0);
        it.knot = ($urandom_range(0, 15) == 0) ? 32'($urandom)
                  : 32'(int'(it.slot) * 65536 + $urandom_range(0, 32767));
      end else begin
        it = blank_item(OP_UNDEF);
        it.slot = 7'($urandom); it.knot = $urandom; it.span = 7'($urandom);
        it.t = $urandom; it.cx = $urandom; it.w = 31'($urandom);
      end
      send_item(it);
    end
  endtask

  initial begin
    repeat (11) @(posedge clk);
    @(negedge clk);
    rst = 0;
    test_table_fill();
    test_directed();
    test_rational();
    write_mode(0);
    test_random_mix(100);
    write_mode(1);
    test_random_mix(100);
    write_mode(0);
    test_random_mix(100);
    write_mode(1);
    quiet = 1;
    test_random_mix(100);
    in_valid = 0;
    wait (pending_results.size() == 0);
    repeat (LATENCY + 50) @(posedge clk);
    if (error_count == 0) begin
      $display("testbench: done, clean");
    end else begin
      $display("testbench: done, errors");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("testbench: done, errors");
    $finish;
  end

endmodule

[cubic_bspline_point_tangent_eval.f]
design/cbs_pkg.sv
design/cbs_div.sv
design/cbs_blend.sv
design/cubic_bspline_point_tangent_eval.sv
verif/testbench.sv
